/* rtl/fcl_pkg.sv */
// Shared types and constants of the fully connected layer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fcl_pkg;

   localparam int DIM_W       = 7;   // dimension registers and element counter
   localparam int IDX_W       = 6;   // output index
   localparam int ACC_W       = 40;  // dot product accumulator incl. bias headroom
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IN_DIM   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_DIM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_BIAS = 2'd2;

   localparam logic [1:0] OP_WEIGHT  = 2'd0;
   localparam logic [1:0] OP_BIAS    = 2'd1;
   localparam logic [1:0] OP_ELEMENT = 2'd2;

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [5:0]         out_row;
      logic [5:0]         in_col;
      logic signed [15:0] sample;
      logic signed [31:0] bias_value;
   } fcl_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   out_index;
      logic signed [31:0] out_value;
      logic               last_of_row;
   } fcl_rsp_type;

   typedef enum logic [1:0] {
      CMD_WEIGHT,
      CMD_BIAS,
      CMD_ELEM,
      CMD_ROW
   } fcl_cmd_kind_type;

   // one queued command from the front end to the compute engine
   typedef struct packed {
      fcl_cmd_kind_type   kind;
      logic [5:0]         row;
      logic [5:0]         col;
      logic [DIM_W-1:0]   slot;
      logic signed [31:0] data;
      logic [DIM_W-1:0]   ni;
      logic [DIM_W-1:0]   no;
      logic               use_bias;
   } fcl_cmd_type;

endpackage

`default_nettype wire

/* rtl/fully_connected_layer.sv */
// Fully connected layer top level: front end, command queue, compute engine.
// Depends on fcl_pkg, fcl_front, fcl_queue and fcl_back.
//
// A word is taken when start is high and busy is low. Weight, bias and
// row words pass the front end combinationally and are written into a
// four-word command queue; busy is high only while that queue is full. The
// word that completes a row makes the compute engine issue in_dim x out_dim
// products, one multiply-accumulate per cycle on its single shared unit;
// result j goes through the read, product, accumulate and output registers
// after the cycle that issues its last product. Results of a row come out in
// order of j, and no command is popped until the row is done. Reset does not
// clear the memories. Each result shows on rsp_valid for one cycle and must
// be taken then: there is no back pressure on this port.
`timescale 1ns / 1ps
`default_nettype none

module fully_connected_layer #(
   parameter int MAX_IN  = 64,
   parameter int MAX_OUT = 64
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  fcl_pkg::fcl_req_type           req_payload,
   output logic                           rsp_valid,
   output fcl_pkg::fcl_rsp_type           rsp_payload,
   input  wire                            csr_we,
   input  wire [fcl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [fcl_pkg::DIM_W-1:0]       csr_wdata
);
   import fcl_pkg::*;

   logic        q_push;
   logic        q_pop;
   logic        q_full;
   logic        q_empty;
   fcl_cmd_type q_entry;
   fcl_cmd_type q_head;

   assign busy = q_full;

   fcl_front #(
      .MAX_IN  (MAX_IN),
      .MAX_OUT (MAX_OUT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   fcl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   fcl_back #(
      .MAX_IN  (MAX_IN),
      .MAX_OUT (MAX_OUT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* rtl/fcl_front.sv */
// Front end: config registers, input word classification and element counting.
// Depends on fcl_pkg; pushes commands into fcl_queue.
`timescale 1ns / 1ps
`default_nettype none

module fcl_front #(
   parameter int MAX_IN  = 64,
   parameter int MAX_OUT = 64
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  fcl_pkg::fcl_req_type           req_payload,
   input  wire                            csr_we,
   input  wire [fcl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [fcl_pkg::DIM_W-1:0]       csr_wdata,
   input  wire                            q_full,
   output logic                           q_push,
   output fcl_pkg::fcl_cmd_type           q_entry
);
   import fcl_pkg::*;

   logic [DIM_W-1:0] in_dim_ff;
   logic [DIM_W-1:0] out_dim_ff;
   logic             has_bias_ff;
   logic [DIM_W-1:0] count_ff;
   logic [DIM_W-1:0] count_in;
   logic [DIM_W-1:0] count_plus;
   logic [DIM_W-1:0] ni;
   logic [DIM_W-1:0] no;
   logic             accept;

   // zero acts as one, oversize acts as the buffer limit
   always_comb begin
      if (in_dim_ff == '0) begin
         ni = DIM_W'(1);
      end else if (int'(in_dim_ff) > MAX_IN) begin
         ni = DIM_W'(MAX_IN);
      end else begin
         ni = in_dim_ff;
      end
      if (out_dim_ff == '0) begin
         no = DIM_W'(1);
      end else if (int'(out_dim_ff) > MAX_OUT) begin
         no = DIM_W'(MAX_OUT);
      end else begin
         no = out_dim_ff;
      end
   end

   assign accept     = start && !q_full;
   assign count_plus = count_ff + DIM_W'(1);

   always_comb begin
      q_entry          = '0;
      q_entry.kind     = CMD_ELEM;
      q_entry.row      = req_payload.out_row;
      q_entry.col      = req_payload.in_col;
      q_entry.slot     = count_ff;
      q_entry.ni       = ni;
      q_entry.no       = no;
      q_entry.use_bias = has_bias_ff;
      q_entry.data     = (req_payload.opcode == OP_BIAS) ? req_payload.bias_value
                                                         : 32'(req_payload.sample);
      q_push           = 1'b0;
      count_in         = count_ff;
      if (accept) begin
         case (req_payload.opcode)
            OP_WEIGHT: begin
               if (int'(req_payload.out_row) < MAX_OUT && int'(req_payload.in_col) < MAX_IN)
               begin
                  q_push       = 1'b1;
                  q_entry.kind = CMD_WEIGHT;
               end
            end
            OP_BIAS: begin
               if (int'(req_payload.out_row) < MAX_OUT) begin
                  q_push       = 1'b1;
                  q_entry.kind = CMD_BIAS;
               end
            end
            OP_ELEMENT: begin
               q_push = 1'b1;
               if (count_plus >= ni) begin
                  q_entry.kind = CMD_ROW;
                  count_in     = '0;
               end else begin
                  q_entry.kind = CMD_ELEM;
                  count_in     = count_plus;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_dim_ff   <= DIM_W'(64);
         out_dim_ff  <= DIM_W'(64);
         has_bias_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            case (csr_index)
               CSR_IN_DIM:   in_dim_ff   <= csr_wdata;
               CSR_OUT_DIM:  out_dim_ff  <= csr_wdata;
               CSR_HAS_BIAS: has_bias_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/fcl_queue.sv */
// Small command FIFO between the front end and the compute engine.
// Depends on fcl_pkg for the command word type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module fcl_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  fcl_pkg::fcl_cmd_type   push_entry,
   input  wire                    pop,
   output fcl_pkg::fcl_cmd_type   head,
   output logic                   full,
   output logic                   empty
);
   import fcl_pkg::*;

   fcl_cmd_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   fill_ff;
   logic [QPTR_W:0]   fill_in;

   assign head  = entries_ff[rd_ptr_ff];
   assign full  = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/fcl_back.sv */
// Compute engine: weight, bias and row memories and one shared multiply-accumulate.
// Depends on fcl_pkg; pops commands from fcl_queue, drives the result port.
`timescale 1ns / 1ps
`default_nettype none

module fcl_back #(
   parameter int MAX_IN  = 64,
   parameter int MAX_OUT = 64
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    q_empty,
   input  fcl_pkg::fcl_cmd_type   q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   output fcl_pkg::fcl_rsp_type   rsp_payload
);
   import fcl_pkg::*;

   localparam int W_DEPTH = MAX_OUT * MAX_IN;
   localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int RB_AW   = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
   localparam int BA_W    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   logic signed [15:0] wmem [W_DEPTH];
   logic signed [31:0] bmem [MAX_OUT];
   logic signed [15:0] rbuf [MAX_IN];

   state_type        state_ff;
   logic [DIM_W-1:0] k_ff;
   logic [IDX_W-1:0] j_ff;
   logic [WA_W-1:0]  wbase_ff;
   logic [DIM_W-1:0] ni_ff;
   logic [DIM_W-1:0] no_ff;
   logic             bias_en_ff;

   logic             issue;
   logic             last_k;
   logic             last_j;
   logic             w_we;
   logic             b_we;
   logic             r_we;
   logic [WA_W-1:0]  w_waddr;
   logic [WA_W-1:0]  w_raddr;

   // stage 1: memory read data
   logic               s1_valid_ff;
   logic               s1_first_ff;
   logic               s1_last_k_ff;
   logic               s1_last_j_ff;
   logic [IDX_W-1:0]   s1_j_ff;
   logic               s1_use_bias_ff;
   logic signed [15:0] w_rd_ff;
   logic signed [15:0] x_rd_ff;
   logic signed [31:0] b_rd_ff;

   // stage 2: product
   logic               s2_valid_ff;
   logic               s2_first_ff;
   logic               s2_last_k_ff;
   logic               s2_last_j_ff;
   logic [IDX_W-1:0]   s2_j_ff;
   logic signed [31:0] s2_bias_ff;
   logic signed [31:0] prod_ff;

   // stage 3: accumulate
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic                    fin_valid_ff;
   logic                    fin_last_j_ff;
   logic [IDX_W-1:0]        fin_j_ff;
   logic signed [31:0]      fin_bias_ff;

   // stage 4: bias add and saturation
   logic signed [ACC_W-1:0] sum_w;
   logic signed [31:0]      sat_value;
   logic                    rsp_valid_ff;
   fcl_rsp_type             rsp_payload_ff;

   assign q_pop  = (state_ff == ST_IDLE) && !q_empty;
   assign issue  = (state_ff == ST_RUN);
   assign last_k = (k_ff == ni_ff - DIM_W'(1));
   assign last_j = ({1'b0, j_ff} == no_ff - DIM_W'(1));

   assign w_we    = q_pop && (q_head.kind == CMD_WEIGHT);
   assign b_we    = q_pop && (q_head.kind == CMD_BIAS);
   assign r_we    = q_pop && (q_head.kind == CMD_ELEM || q_head.kind == CMD_ROW)
                    && (int'(q_head.slot) < MAX_IN);
   assign w_waddr = WA_W'(q_head.row) * WA_W'(MAX_IN) + WA_W'(q_head.col);
   assign w_raddr = wbase_ff + WA_W'(k_ff);

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_waddr] <= q_head.data[15:0];
      end
      w_rd_ff <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bmem[BA_W'(q_head.row)] <= q_head.data;
      end
      b_rd_ff <= bmem[BA_W'(j_ff)];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         rbuf[RB_AW'(q_head.slot)] <= q_head.data[15:0];
      end
      x_rd_ff <= rbuf[RB_AW'(k_ff)];
   end

   // sequencer: walks k inside j, one product per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (q_pop && q_head.kind == CMD_ROW) begin
                  state_ff   <= ST_RUN;
                  k_ff       <= '0;
                  j_ff       <= '0;
                  wbase_ff   <= '0;
                  ni_ff      <= q_head.ni;
                  no_ff      <= q_head.no;
                  bias_en_ff <= q_head.use_bias;
               end
            end
            ST_RUN: begin
               if (last_k) begin
                  k_ff     <= '0;
                  j_ff     <= j_ff + IDX_W'(1);
                  wbase_ff <= wbase_ff + WA_W'(MAX_IN);
                  if (last_j) begin
                     state_ff <= ST_IDLE;
                  end
               end else begin
                  k_ff <= k_ff + DIM_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         fin_valid_ff <= s2_valid_ff && s2_last_k_ff;
         rsp_valid_ff <= fin_valid_ff;
      end
   end

   always_comb begin
      if (s2_first_ff) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   assign sum_w = acc_ff + ACC_W'(fin_bias_ff);

   always_comb begin
      if (sum_w[ACC_W-1:31] == '0 || sum_w[ACC_W-1:31] == '1) begin
         sat_value = sum_w[31:0];
      end else if (sum_w[ACC_W-1]) begin
         sat_value = SAT_MIN;
      end else begin
         sat_value = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff    <= (k_ff == '0);
      s1_last_k_ff   <= last_k;
      s1_last_j_ff   <= last_j;
      s1_j_ff        <= j_ff;
      s1_use_bias_ff <= bias_en_ff;

      s2_first_ff  <= s1_first_ff;
      s2_last_k_ff <= s1_last_k_ff;
      s2_last_j_ff <= s1_last_j_ff;
      s2_j_ff      <= s1_j_ff;
      s2_bias_ff   <= s1_use_bias_ff ? b_rd_ff : '0;
      prod_ff      <= x_rd_ff * w_rd_ff;

      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      fin_last_j_ff <= s2_last_j_ff;
      fin_j_ff      <= s2_j_ff;
      fin_bias_ff   <= s2_bias_ff;

      rsp_payload_ff.out_index   <= fin_j_ff;
      rsp_payload_ff.out_value   <= sat_value;
      rsp_payload_ff.last_of_row <= fin_last_j_ff;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

/* rtl/fcl_checker.sv */
// Port-level checks of the fully connected layer, bound to the top level.
// Depends on fcl_pkg and fully_connected_layer.
`timescale 1ns / 1ps
`default_nettype none

module fcl_port_checks (
   input wire                    clock,
   input wire                    reset,
   input wire                    start,
   input wire                    busy,
   input wire                    rsp_valid,
   input fcl_pkg::fcl_rsp_type   rsp_payload
);
   import fcl_pkg::*;

   logic [IDX_W-1:0] exp_index_ff;
   logic [IDX_W-1:0] exp_index_in;

   // results of a row count up from zero and restart after the marked one
   always_comb begin
      exp_index_in = exp_index_ff;
      if (rsp_valid) begin
         exp_index_in = rsp_payload.last_of_row ? '0 : rsp_payload.out_index + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_index_ff <= '0;
      end else begin
         exp_index_ff <= exp_index_in;
      end
   end

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.out_index == exp_index_ff)
      else $error("result index out of sequence");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("busy or result right after reset");

   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && !busy))
      else $error("busy rose without an accepted word");

endmodule

bind fully_connected_layer fcl_port_checks u_fcl_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
